/* hdl/clnsq_pkg.sv */
// Shared types, codes and constants for the character LCD nibble sequencer.
// No dependencies; imported by every module of the block.
package clnsq_pkg;

  // Display geometry
  localparam int NUM_COLUMNS = 20;
  localparam int NUM_ROWS    = 4;

  // Job queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Timing constants in microseconds
  localparam logic [17:0] POWERUP_US   = 18'd60000;
  localparam logic [17:0] CMD_US       = 18'd1000;
  localparam logic [17:0] CLEAR_US     = 18'd200000;
  localparam logic [17:0] WAKE1_US     = 18'd5000;
  localparam logic [17:0] WAKE2_US     = 18'd1000;
  localparam logic [17:0] WAKE3_US     = 18'd10000;
  localparam logic [17:0] INIT_TAIL_US = 18'd11000;   // command delay plus 10 ms

  // LCD command bytes
  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
  localparam logic [7:0] CMD_FSET_4BIT = 8'h20;
  localparam logic [7:0] CMD_FSET_4LN  = 8'h28;
  localparam logic [7:0] CMD_DISP_OFF  = 8'h08;
  localparam logic [7:0] CMD_ENTRY     = 8'h06;
  localparam logic [7:0] CMD_DISP_ON   = 8'h0C;
  localparam logic [3:0] WAKE_NIBBLE   = 4'h3;

  // Init sequence layout: one quiet phase, three wake nibbles, six bytes
  localparam logic [4:0] INIT_BYTE_STEP = 5'd7;
  localparam logic [4:0] INIT_LAST_STEP = 5'd30;

  // Input item kinds
  typedef enum logic [1:0] {
    KIND_INIT   = 2'd0,
    KIND_CMD    = 2'd1,
    KIND_DATA   = 2'd2,
    KIND_CURSOR = 2'd3
  } kind_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_FOUR_LINE  = 3'd0,
    REG_SECOND_OFS = 3'd1,
    REG_THIRD_OFS  = 3'd2,
    REG_FOURTH_OFS = 3'd3,
    REG_ENABLE_US  = 3'd4
  } reg_index_t;

  // Extra delay on the final low phase of a byte
  typedef enum logic [1:0] {
    EXTRA_NONE  = 2'd0,
    EXTRA_CMD   = 2'd1,
    EXTRA_CLEAR = 2'd2
  } extra_t;

  // One classified job as it sits in the queue
  typedef struct packed {
    logic       init;
    logic       rs;
    logic [7:0] data;
    extra_t     extra;
  } job_t;

  // Bytes of the init sequence after the wake nibbles
  function automatic logic [7:0] init_byte(input logic [2:0] idx, input logic four_line);
    logic [7:0] b;
    case (idx)
      3'd0:    b = CMD_FSET_4BIT;
      3'd1:    b = four_line ? CMD_FSET_4LN : CMD_FSET_4BIT;
      3'd2:    b = CMD_DISP_OFF;
      3'd3:    b = CMD_CLEAR;
      3'd4:    b = CMD_ENTRY;
      3'd5:    b = CMD_DISP_ON;
      default: b = CMD_DISP_ON;
    endcase
    return b;
  endfunction

endpackage

/* hdl/char_lcd_nibble_sequencer_core.sv */
// Top level of the character LCD nibble sequencer: configuration registers and wiring.
// Depends on clnsq_pkg, clnsq_front, clnsq_queue and clnsq_back.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  in       | in_valid / in_ready   | kind, value, row, column
//  out      | out_valid / out_ready | register_select, nibble, enable, hold_us, last
//  cfg      | cfg_we                | cfg_index, cfg_data
//
// One pin phase leaves per cycle while out_ready does not hold the output. The single
// phase sequencer in the back end steps each byte as a high and a low phase per nibble.
// The front end classifies an item in the cycle it is taken and queues it (4 jobs),
// so input is taken while the sequencer or the output stalls, until the queue is full.
// A job's first phase is registered once it is at the queue head and the output advances.
// Reset is synchronous; it empties the queue and loads register defaults.
module char_lcd_nibble_sequencer_core
  import clnsq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [7:0]  value,
  input  logic [7:0]  row,
  input  logic [7:0]  column,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        register_select,
  output logic [3:0]  nibble,
  output logic        enable,
  output logic [17:0] hold_us,
  output logic        last
);

  logic       four_line_mode;
  logic [6:0] second_row_offset;
  logic [6:0] third_row_offset;
  logic [6:0] fourth_row_offset;
  logic [9:0] enable_us;

  job_t       front_job;
  job_t       head_job;
  logic       q_full;
  logic       head_valid;
  logic       pop;
  logic       push;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      four_line_mode    <= 1'b1;
      second_row_offset <= 7'd64;
      third_row_offset  <= 7'd20;
      fourth_row_offset <= 7'd84;
      enable_us         <= 10'd50;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_FOUR_LINE:  four_line_mode    <= cfg_data[0];
        REG_SECOND_OFS: second_row_offset <= cfg_data[6:0];
        REG_THIRD_OFS:  third_row_offset  <= cfg_data[6:0];
        REG_FOURTH_OFS: fourth_row_offset <= cfg_data[6:0];
        REG_ENABLE_US:  enable_us         <= cfg_data;
        default:        enable_us         <= enable_us;
      endcase
    end
  end

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  clnsq_front u_front (
    .kind              (kind),
    .value             (value),
    .row               (row),
    .column            (column),
    .four_line_mode    (four_line_mode),
    .second_row_offset (second_row_offset),
    .third_row_offset  (third_row_offset),
    .fourth_row_offset (fourth_row_offset),
    .job               (front_job)
  );

  clnsq_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (front_job),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  clnsq_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head_valid      (head_valid),
    .head_job        (head_job),
    .pop             (pop),
    .four_line_mode  (four_line_mode),
    .enable_us       (enable_us),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .register_select (register_select),
    .nibble          (nibble),
    .enable          (enable),
    .hold_us         (hold_us),
    .last            (last)
  );

endmodule

/* hdl/clnsq_front.sv */
// Front end: classifies an input item into a queue job and computes cursor addresses.
// Depends on clnsq_pkg.
module clnsq_front
  import clnsq_pkg::*;
(
  input  logic [1:0] kind,
  input  logic [7:0] value,
  input  logic [7:0] row,
  input  logic [7:0] column,
  input  logic       four_line_mode,
  input  logic [6:0] second_row_offset,
  input  logic [6:0] third_row_offset,
  input  logic [6:0] fourth_row_offset,
  output job_t       job
);

  logic [2:0] row_c;
  logic [5:0] col_c;
  logic [6:0] col_m1;
  logic [6:0] row_ofs;
  logic [6:0] addr;

  // Clamp row and column
  always_comb begin
    if (row == 8'd0) begin
      row_c = 3'd1;
    end else if (row > 8'(NUM_ROWS)) begin
      row_c = 3'(NUM_ROWS);
    end else begin
      row_c = row[2:0];
    end
    if (column == 8'd0) begin
      col_c = 6'd1;
    end else if (column > 8'(NUM_COLUMNS)) begin
      col_c = 6'(NUM_COLUMNS);
    end else begin
      col_c = column[5:0];
    end
    col_m1 = {1'b0, col_c} - 7'd1;
  end

  // Row offset and DDRAM address (wraps at 7 bits)
  always_comb begin
    row_ofs = 7'd0;
    addr    = 7'd0;
    if (four_line_mode) begin
      case (row_c)
        3'd2:    row_ofs = second_row_offset;
        3'd3:    row_ofs = third_row_offset;
        3'd4:    row_ofs = fourth_row_offset;
        default: row_ofs = 7'd0;
      endcase
      addr = row_ofs + col_m1;
    end else begin
      case (row_c)
        3'd1:    addr = col_m1;
        3'd3:    addr = second_row_offset + col_m1;
        default: addr = 7'd0;
      endcase
    end
  end

  // Classify
  always_comb begin
    job.init  = 1'b0;
    job.rs    = 1'b0;
    job.data  = value;
    job.extra = EXTRA_NONE;
    case (kind_t'(kind))
      KIND_INIT: begin
        job.init = 1'b1;
      end
      KIND_CMD: begin
        job.extra = (value == CMD_CLEAR) ? EXTRA_CLEAR : EXTRA_CMD;
      end
      KIND_DATA: begin
        job.rs = 1'b1;
      end
      KIND_CURSOR: begin
        job.data = CMD_SET_DDRAM | {1'b0, addr};
      end
      default: begin
        job.init = 1'b0;
      end
    endcase
  end

endmodule

/* hdl/clnsq_queue.sv */
// Short job queue between the front end and the phase sequencer.
// Depends on clnsq_pkg.
module clnsq_queue
  import clnsq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output job_t head_job
);

  job_t                mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign full       = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* hdl/clnsq_back.sv */
// Back end: steps through the pin phases of the head job into the output register.
// Depends on clnsq_pkg.
module clnsq_back
  import clnsq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  job_t        head_job,
  output logic        pop,
  input  logic        four_line_mode,
  input  logic [9:0]  enable_us,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        register_select,
  output logic [3:0]  nibble,
  output logic        enable,
  output logic [17:0] hold_us,
  output logic        last
);

  logic [4:0]  step;
  logic        advance;
  logic [4:0]  t;
  logic [1:0]  sub;
  logic [7:0]  cur_byte;
  logic [17:0] extra_us;
  logic        ph_rs;
  logic [3:0]  ph_nib;
  logic        ph_en;
  logic [17:0] ph_hold;
  logic        ph_last;
  logic        quiet;

  // Phase decode from job and step
  always_comb begin
    t        = step - INIT_BYTE_STEP;
    sub      = head_job.init ? t[1:0] : step[1:0];
    cur_byte = head_job.init ? init_byte(t[4:2], four_line_mode) : head_job.data;
    quiet    = 1'b0;
    extra_us = '0;
    ph_rs    = head_job.rs;
    ph_nib   = sub[1] ? cur_byte[3:0] : cur_byte[7:4];
    ph_en    = ~sub[0];
    ph_last  = 1'b0;
    if (head_job.init) begin
      ph_last = (step == INIT_LAST_STEP);
      if (step == 5'd0) begin
        quiet  = 1'b1;
        ph_nib = 4'h0;
        ph_en  = 1'b0;
      end else if (step < INIT_BYTE_STEP) begin
        // Wake nibbles: odd steps high, even steps low with their own delay
        ph_nib = WAKE_NIBBLE;
        ph_en  = step[0];
        case (step)
          5'd2:    extra_us = WAKE1_US;
          5'd4:    extra_us = WAKE2_US;
          5'd6:    extra_us = WAKE3_US;
          default: extra_us = '0;
        endcase
      end else if (sub == 2'd3) begin
        case (t[4:2])
          3'd3:    extra_us = CLEAR_US;
          3'd5:    extra_us = INIT_TAIL_US;
          default: extra_us = CMD_US;
        endcase
      end
    end else begin
      ph_last = (sub == 2'd3);
      if (sub == 2'd3) begin
        case (head_job.extra)
          EXTRA_CMD:   extra_us = CMD_US;
          EXTRA_CLEAR: extra_us = CLEAR_US;
          default:     extra_us = '0;
        endcase
      end
    end
    if (quiet) begin
      ph_hold = POWERUP_US;
    end else if (ph_en) begin
      ph_hold = {8'd0, enable_us};
    end else begin
      ph_hold = {8'd0, enable_us} + extra_us;
    end
  end

  assign advance = !out_valid || out_ready;
  assign pop     = advance && head_valid && ph_last;

  // Step counter and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= head_valid;
      if (head_valid) begin
        step <= ph_last ? 5'd0 : step + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && head_valid) begin
      register_select <= ph_rs;
      nibble          <= ph_nib;
      enable          <= ph_en;
      hold_us         <= ph_hold;
      last            <= ph_last;
    end
  end

endmodule
